FILE: rtl/core/fnt_pkg.sv
// shared constants, types and state codes of the feature novelty table
`default_nettype none

package fnt_pkg;

    // default configuration
    localparam int FEATURE_ID_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF      = 6;
    localparam int HEUR_BITS_DEF       = 16;
    localparam int MAX_FEATURES_DEF    = 1024;

    // result field width and its byte-padded stream width
    localparam int OUT_W       = 12;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } t_state;

    // control from the sequencer to the scoring unit
    typedef struct packed {
        logic commit;
        logic last;
        logic unsolv;
        logic skip;
    } t_score_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/feature_novelty_table.sv
// Feature novelty table: scores search states by lowest heuristic per feature key.
// Each item takes a table read, then a compare and write back; no new item is taken
//   before that ends: ready is low in the cycle after each accepted item, and stays
//   low while a last item waits for the sink to free the output register.
// The result of a last item is written to the output register when its update commits.
// Reset: synchronous, active low; a clearing pass over all 2^(FEATURE_ID_BITS+COUNT_BITS)
//   table entries (65536 at default sizes) then runs with no items accepted.
`default_nettype none

module feature_novelty_table #(
    parameter int FEATURE_ID_BITS = fnt_pkg::FEATURE_ID_BITS_DEF,
    parameter int COUNT_BITS      = fnt_pkg::COUNT_BITS_DEF,
    parameter int HEUR_BITS       = fnt_pkg::HEUR_BITS_DEF,
    parameter int MAX_FEATURES    = fnt_pkg::MAX_FEATURES_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // input stream
    input  wire logic                                   i_s_tvalid,
    output logic                                        o_s_tready,
    // feature_id, feature_count, base_heuristic, zero pad
    input  wire logic [((FEATURE_ID_BITS+COUNT_BITS+HEUR_BITS+7)/8)*8-1:0] i_s_tdata,
    // base_unsolvable
    input  wire logic                                   i_s_tuser,
    // last_feature
    input  wire logic                                   i_s_tlast,
    // output stream
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    // novelty_value, zero pad
    output logic [fnt_pkg::OUT_TDATA_W-1:0]             o_m_tdata,
    // unsolvable
    output logic                                        o_m_tuser
);

    localparam int KEY_BITS   = FEATURE_ID_BITS + COUNT_BITS;
    localparam int IN_TDATA_W = ((FEATURE_ID_BITS + COUNT_BITS + HEUR_BITS + 7) / 8) * 8;
    localparam int DEPTH      = 2 ** KEY_BITS;

    logic                        ram_we;
    logic [KEY_BITS-1:0]         ram_waddr;
    logic [HEUR_BITS:0]          ram_wdata;
    logic                        ram_re;
    logic [KEY_BITS-1:0]         ram_raddr;
    logic [HEUR_BITS:0]          ram_rdata;
    fnt_pkg::t_score_ctl         score_ctl;
    logic [HEUR_BITS-1:0]        heur;
    logic                        upd_we;
    logic [fnt_pkg::OUT_W-1:0]   result;

    // sequencer
    fnt_ctrl #(
        .FEATURE_ID_BITS (FEATURE_ID_BITS),
        .COUNT_BITS      (COUNT_BITS),
        .HEUR_BITS       (HEUR_BITS),
        .IN_TDATA_W      (IN_TDATA_W),
        .KEY_BITS        (KEY_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_score_ctl (score_ctl),
        .o_heur      (heur),
        .i_upd_we    (upd_we),
        .i_result    (result)
    );

    // lowest value table with valid flag in the top bit
    fnt_ram #(
        .WIDTH (HEUR_BITS + 1),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // compare and tally unit
    fnt_score #(
        .HEUR_BITS    (HEUR_BITS),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_score (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (score_ctl),
        .i_heur   (heur),
        .i_rdata  (ram_rdata),
        .o_we     (upd_we),
        .o_result (result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/fnt_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module fnt_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fnt_score.sv
// compare unit, novelty and penalty tallies and result formatting
`default_nettype none

module fnt_score #(
    parameter int HEUR_BITS    = fnt_pkg::HEUR_BITS_DEF,
    parameter int MAX_FEATURES = fnt_pkg::MAX_FEATURES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire fnt_pkg::t_score_ctl      i_ctl,
    input  wire logic [HEUR_BITS-1:0]     i_heur,
    input  wire logic [HEUR_BITS:0]       i_rdata,
    output logic                          o_we,
    output logic [fnt_pkg::OUT_W-1:0]     o_result
);

    localparam int TALLY_W = $clog2(MAX_FEATURES + 1);
    localparam int EXT_W   = (TALLY_W > fnt_pkg::OUT_W) ? TALLY_W : fnt_pkg::OUT_W;
    localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(MAX_FEATURES);

    logic [TALLY_W-1:0]   r_nov;
    logic [TALLY_W-1:0]   n_nov;
    logic [TALLY_W-1:0]   r_pen;
    logic [TALLY_W-1:0]   n_pen;
    logic                 stored_valid;
    logic [HEUR_BITS-1:0] stored;
    logic                 active;
    logic                 lower;
    logic                 higher;
    logic [EXT_W-1:0]     nov_neg;
    logic [EXT_W-1:0]     pen_ext;

    // compare item heuristic against the stored lowest value
    always_comb begin
        stored_valid = i_rdata[HEUR_BITS];
        stored       = i_rdata[HEUR_BITS-1:0];
        active       = !i_ctl.unsolv && !i_ctl.skip;
        lower        = active && (!stored_valid || (i_heur < stored));
        higher       = active && stored_valid && (i_heur > stored);
        o_we         = i_ctl.commit && lower;
    end

    // saturating tally bumps including this item
    always_comb begin
        n_nov = r_nov;
        n_pen = r_pen;
        if (lower) begin
            n_nov = (r_nov < TALLY_MAX) ? r_nov + TALLY_W'(1) : TALLY_MAX;
        end
        if (higher) begin
            n_pen = (r_pen < TALLY_MAX) ? r_pen + TALLY_W'(1) : TALLY_MAX;
        end
    end

    // result: minus novelty if any, else penalty, zero when unsolvable
    always_comb begin
        nov_neg = EXT_W'(0) - EXT_W'(n_nov);
        pen_ext = EXT_W'(n_pen);
        if (i_ctl.unsolv) begin
            o_result = '0;
        end else if (n_nov != '0) begin
            o_result = nov_neg[fnt_pkg::OUT_W-1:0];
        end else begin
            o_result = pen_ext[fnt_pkg::OUT_W-1:0];
        end
    end

    // tally registers, cleared at the end of each state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nov <= '0;
            r_pen <= '0;
        end else if (i_ctl.commit) begin
            if (i_ctl.last) begin
                r_nov <= '0;
                r_pen <= '0;
            end else begin
                r_nov <= n_nov;
                r_pen <= n_pen;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fnt_ctrl.sv
// sequencer: clearing pass, item capture, table access and output register
`default_nettype none

module fnt_ctrl #(
    parameter int FEATURE_ID_BITS = fnt_pkg::FEATURE_ID_BITS_DEF,
    parameter int COUNT_BITS      = fnt_pkg::COUNT_BITS_DEF,
    parameter int HEUR_BITS       = fnt_pkg::HEUR_BITS_DEF,
    parameter int IN_TDATA_W      = 32,
    parameter int KEY_BITS        = FEATURE_ID_BITS + COUNT_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input stream
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]        i_s_tdata,
    input  wire logic                         i_s_tuser,
    input  wire logic                         i_s_tlast,
    // output stream
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [fnt_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tuser,
    // table port
    output logic                              o_ram_we,
    output logic [KEY_BITS-1:0]               o_ram_waddr,
    output logic [HEUR_BITS:0]                o_ram_wdata,
    output logic                              o_ram_re,
    output logic [KEY_BITS-1:0]               o_ram_raddr,
    // scoring unit
    output fnt_pkg::t_score_ctl               o_score_ctl,
    output logic [HEUR_BITS-1:0]              o_heur,
    input  wire logic                         i_upd_we,
    input  wire logic [fnt_pkg::OUT_W-1:0]    i_result
);

    localparam int HEUR_LO = FEATURE_ID_BITS + COUNT_BITS;

    fnt_pkg::t_state             r_state;
    fnt_pkg::t_state             n_state;
    logic [KEY_BITS-1:0]         r_clr_addr;
    logic [KEY_BITS-1:0]         r_key;
    logic [HEUR_BITS-1:0]        r_heur;
    logic                        r_unsolv;
    logic                        r_last;
    logic                        r_skip;
    logic                        r_out_valid;
    logic [fnt_pkg::OUT_W-1:0]   r_out_value;
    logic                        r_out_unsolv;
    logic                        accept;
    logic                        out_free;
    logic                        commit;
    logic [FEATURE_ID_BITS-1:0]  in_id;
    logic [COUNT_BITS-1:0]       in_cnt;

    // unpack the input item
    assign in_id  = i_s_tdata[FEATURE_ID_BITS-1:0];
    assign in_cnt = i_s_tdata[HEUR_LO-1:FEATURE_ID_BITS];

    assign out_free = !r_out_valid || i_m_tready;

    // next state and handshake
    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        commit     = 1'b0;
        case (r_state)
            fnt_pkg::ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = fnt_pkg::ST_IDLE;
                end
            end
            fnt_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = fnt_pkg::ST_UPDATE;
                end
            end
            fnt_pkg::ST_UPDATE: begin
                if (!r_last || out_free) begin
                    commit  = 1'b1;
                    n_state = fnt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fnt_pkg::ST_CLEAR;
            end
        endcase
    end

    assign accept = i_s_tvalid && o_s_tready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fnt_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == fnt_pkg::ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + KEY_BITS'(1);
        end
    end

    // capture the accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key    <= {in_id, in_cnt};
            r_heur   <= i_s_tdata[HEUR_LO+HEUR_BITS-1:HEUR_LO];
            r_unsolv <= i_s_tuser;
            r_last   <= i_s_tlast;
            r_skip   <= (in_cnt == '0);
        end
    end

    // table access: read on accept, write on update or during clearing
    always_comb begin
        o_ram_re    = accept;
        o_ram_raddr = {in_id, in_cnt};
        if (r_state == fnt_pkg::ST_CLEAR) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = r_clr_addr;
            o_ram_wdata = '0;
        end else begin
            o_ram_we    = i_upd_we;
            o_ram_waddr = r_key;
            o_ram_wdata = {1'b1, r_heur};
        end
    end

    // scoring unit control
    always_comb begin
        o_score_ctl.commit = commit;
        o_score_ctl.last   = r_last;
        o_score_ctl.unsolv = r_unsolv;
        o_score_ctl.skip   = r_skip;
        o_heur             = r_heur;
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (commit && r_last) begin
            r_out_value  <= i_result;
            r_out_unsolv <= r_unsolv;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = fnt_pkg::OUT_TDATA_W'(r_out_value);
    assign o_m_tuser  = r_out_unsolv;

endmodule

`default_nettype wire

FILE: rtl/core/fnt_checker.sv
// port-level checks of the feature novelty table, bound to the top level
`default_nettype none

module fnt_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_s_tvalid,
    input wire logic                               o_s_tready,
    input wire logic                               i_s_tlast,
    input wire logic                               o_m_tvalid,
    input wire logic                               i_m_tready,
    input wire logic [fnt_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input wire logic                               o_m_tuser
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output item changed while stalled");

    // the block takes no new item directly after it accepts one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("item accepted in back-to-back cycles");

    // an item that does not end a state never produces a result
    a_no_result_mid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tlast && !o_m_tvalid |=> ##1 !o_m_tvalid)
        else $error("result without a last item");

    // an unsolvable state reports a zero score
    a_unsolvable_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[fnt_pkg::OUT_W-1:0] == '0)
        else $error("unsolvable state with nonzero score");

endmodule

bind feature_novelty_table fnt_checker u_fnt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
